>>> src/bounded_stable_priority_queue_assert.svh
// Assertion macros for the bounded stable priority queue.
`ifndef BOUNDED_STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define BOUNDED_STABLE_PRIORITY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BSQ_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

`define BSQ_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`else

`define BSQ_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg)

`define BSQ_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)

`endif

`endif

>>> src/bsq_pkg.sv
// Shared types and constants of the bounded stable priority queue.
`default_nettype none

package bsq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int PRIO_W = 32;
	localparam int TAG_W = 16;
	localparam int CAP_W = 5;
	localparam int CNT_OUT_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic                     op;
		logic signed [PRIO_W-1:0] priority_req;
		logic [TAG_W-1:0]         task_tag;
	} req_item_t;

	typedef struct packed {
		logic                     accepted;
		logic                     head_valid;
		logic signed [PRIO_W-1:0] head_priority;
		logic [TAG_W-1:0]         head_tag;
		logic [CNT_OUT_W-1:0]     entry_count;
		logic                     empty_flag;
	} rsp_item_t;

	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]         tag;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t item;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/bsq_cell.sv
// One slot of the queue: holds an entry, compares it with the new item, shifts with neighbors.
`default_nettype none

module bsq_cell (
	input  wire                  clk,
	input  wire bsq_pkg::cell_ctrl_t ctrl,
	input  wire                  occupied,
	input  wire                  here_left,
	input  wire bsq_pkg::entry_t left_slot,
	input  wire bsq_pkg::entry_t right_slot,
	output logic                 here,
	output bsq_pkg::entry_t      slot,
	output bsq_pkg::entry_t      slot_next
);

	bsq_pkg::entry_t slot_q;

	assign slot = slot_q;

	always_comb begin
		here = !occupied || (slot_q.prio < ctrl.item.prio);
		slot_next = slot_q;
		if (ctrl.ins) begin
			if (here) begin
				slot_next = here_left ? left_slot : ctrl.item;
			end
		end else if (ctrl.rem) begin
			slot_next = right_slot;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_next;
	end

endmodule

`default_nettype wire

>>> src/bounded_stable_priority_queue.sv
// Top level of the bounded stable priority queue: cell chain, count, capacity and result register.
`default_nettype none

`include "bounded_stable_priority_queue_assert.svh"

// Bounded stable priority queue. Entries are kept highest priority first; equal
// priorities leave in arrival order. An insert (op 0) is refused when the count has
// reached the capacity register (saturated at DEPTH); a remove (op 1) drops the head
// and is refused when empty. Each request item yields one response item describing
// the queue after the step. One item is taken per cycle unless a response is stalled:
// every slot cell compares its entry with the new priority in parallel and shifts in
// the same clock, and the response register accepts a new item in the cycle its
// previous item is taken. Write the capacity only while no response is pending.
module bounded_stable_priority_queue #(
	parameter int DEPTH = bsq_pkg::DEPTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_ready,
	input  wire bsq_pkg::req_item_t      req_item,
	output logic                         rsp_valid,
	input  wire                          rsp_ready,
	output bsq_pkg::rsp_item_t           rsp_item,
	input  wire                          cfg_we,
	input  wire [bsq_pkg::CAP_W-1:0]     cfg_data
);

	localparam int CntW = $clog2(DEPTH + 1);
	localparam int CmpW = (CntW > bsq_pkg::CAP_W) ? CntW : bsq_pkg::CAP_W;

	logic [CntW-1:0]           count_q, count_d;
	logic [bsq_pkg::CAP_W-1:0] cap_q;
	logic                      rsp_valid_q;
	bsq_pkg::rsp_item_t        rsp_item_q;

	logic [CmpW-1:0] cnt_cmp, cap_cmp, cnt_d_cmp;
	logic            room, nonempty, is_ins, fire, ok;
	bsq_pkg::cell_ctrl_t ctrl;

	logic [DEPTH-1:0]     here;
	logic [DEPTH-1:0]     occ;
	bsq_pkg::entry_t      slot [DEPTH];
	bsq_pkg::entry_t      slot_next [DEPTH];

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign fire      = req_valid && req_ready;

	always_comb begin
		cnt_cmp   = CmpW'(count_q);
		cap_cmp   = CmpW'(cap_q);
		room      = (cnt_cmp < cap_cmp) && (cnt_cmp < CmpW'(DEPTH));
		nonempty  = (count_q != '0);
		is_ins    = (req_item.op == bsq_pkg::OP_INSERT);
		ok        = is_ins ? room : nonempty;
		ctrl.ins  = fire && is_ins && room;
		ctrl.rem  = fire && !is_ins && nonempty;
		ctrl.item.prio = req_item.priority_req;
		ctrl.item.tag  = req_item.task_tag;
		count_d = count_q;
		if (ctrl.ins) begin
			count_d = count_q + CntW'(1);
		end else if (ctrl.rem) begin
			count_d = count_q - CntW'(1);
		end
		cnt_d_cmp = CmpW'(count_d);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bsq_pkg::entry_t left_slot, right_slot;
		logic            here_left;

		assign occ[i] = (CntW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_slot = slot[i];
			assign here_left = 1'b0;
		end else begin : g_body
			assign left_slot = slot[i-1];
			assign here_left = here[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_slot = slot[i];
		end else begin : g_mid
			assign right_slot = slot[i+1];
		end

		bsq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (occ[i]),
			.here_left  (here_left),
			.left_slot  (left_slot),
			.right_slot (right_slot),
			.here       (here[i]),
			.slot       (slot[i]),
			.slot_next  (slot_next[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= bsq_pkg::CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_item_q.accepted      <= ok;
			rsp_item_q.head_valid    <= (count_d != '0);
			rsp_item_q.head_priority <= (count_d != '0) ? slot_next[0].prio : '0;
			rsp_item_q.head_tag      <= (count_d != '0) ? slot_next[0].tag : '0;
			rsp_item_q.entry_count   <= cnt_d_cmp[bsq_pkg::CNT_OUT_W-1:0];
			rsp_item_q.empty_flag    <= (count_d == '0);
		end
	end

	`BSQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CntW'(DEPTH), "count exceeds depth")
	`BSQ_ASSERT(a_fire_rsp, clk, arst_n, fire |=> rsp_valid_q, "accepted item gave no response")
	`BSQ_ASSERT(a_empty_remove, clk, arst_n, (fire && !is_ins && !nonempty) |=> (!rsp_item_q.accepted && count_q == '0), "remove on empty queue not refused")
	`BSQ_ASSERT(a_full_insert, clk, arst_n, (fire && is_ins && !room) |=> (!rsp_item_q.accepted && $stable(count_q)), "insert past capacity not refused")

endmodule

`default_nettype wire
